>>> sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int DataWidth  = 32;
  localparam int ActWidth   = 3;
  localparam int CntWidth   = $clog2(DataWidth + 1);

  typedef logic [DataWidth-1:0] word_t;

  typedef enum logic [ActWidth-1:0] {
    ACT_MUL = 3'd0,
    ACT_DIV = 3'd1,
    ACT_ADD = 3'd2,
    ACT_SUB = 3'd3,
    ACT_RED = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_GCD,
    ST_LCD,
    ST_Q1,
    ST_Q2,
    ST_T1,
    ST_T2,
    ST_RN,
    ST_RD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ActWidth-1:0] action;
    word_t               a_num;
    word_t               a_den;
    word_t               b_num;
    word_t               b_den;
  } req_t;

  typedef struct packed {
    word_t res_num;
    word_t res_den;
    logic  zero_den_error;
  } rsp_t;

  function automatic word_t mag(input word_t v);
    mag = v[DataWidth-1] ? word_t'(-v) : v;
  endfunction

endpackage

>>> sv/rau_if.sv
// ----------------------------------------------------------------------------
// rau_req_if / rau_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface rau_req_if import rau_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/rau_serial.sv
// ----------------------------------------------------------------------------
// rau_serial
// Bit-serial unit: shift-add multiply, restoring divide and remainder.
// One bit per cycle: a load cycle, DataWidth steps, then one done cycle.
// ----------------------------------------------------------------------------
module rau_serial import rau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  is_div,
  input  word_t x,
  input  word_t y,
  output logic  busy,
  output logic  done,
  output word_t prod,
  output word_t quot,
  output word_t rem
);

  logic [CntWidth-1:0] cnt;
  word_t  acc;
  word_t  sh;
  word_t  opy;
  logic   mode;
  logic [DataWidth:0] trial;

  assign trial = {acc, sh[DataWidth-1]} - {1'b0, opy};
  assign prod  = acc;
  assign quot  = sh;
  assign rem   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CntWidth'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntWidth'(DataWidth);
        acc  <= '0;
        sh   <= x;
        opy  <= y;
        mode <= is_div;
      end else if (busy) begin
        if (mode) begin
          // restoring step: shift in dividend bit, subtract if it fits
          if (!trial[DataWidth]) begin
            acc <= trial[DataWidth-1:0];
            sh  <= {sh[DataWidth-2:0], 1'b1};
          end else begin
            acc <= {acc[DataWidth-2:0], sh[DataWidth-1]};
            sh  <= {sh[DataWidth-2:0], 1'b0};
          end
        end else begin
          // multiply from LSB of x up, low word only
          if (sh[0]) acc <= acc + opy;
          sh  <= sh >> 1;
          opy <= opy << 1;
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> sv/rational_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Fraction multiply, divide, add, subtract and reduce over a serial unit.
// ----------------------------------------------------------------------------
// Usage: a request transaction on req carries the action code and the two
// fractions; one result transaction on rsp follows with numerator,
// denominator and zero_den_error. One request is processed at a time.
// All products and quotients go through one bit-serial multiply/divide
// unit: multiply and divide use two passes; reduce runs a Euclid gcd
// (one remainder per step, up to ~46 steps) plus two divides; add and
// subtract run the gcd plus seven passes. req is ready only while idle.
// The result sits in an output register until taken; a stalled receiver
// holds the block in that state. Synchronous reset returns the block to
// idle with no result pending. Operand denominators of zero (bar b_den
// for divide, which only zeroes the numerator), unused codes, or a zero
// result denominator give zero_den_error with zero fields.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top import rau_pkg::*; (
  input logic     clk,
  input logic     rst,
  rau_req_if.sink req,
  rau_rsp_if.source rsp
);

  state_t state, state_next;
  req_t   r;
  word_t  lcd, q1, q2, t1, rn, rd, gx, gy, p0;
  logic   bad;

  logic   s_start, s_div, s_busy, s_done;
  word_t  s_x, s_y, s_prod, s_quot, s_rem;

  rau_serial u_serial (
    .clk, .rst, .start(s_start), .is_div(s_div), .x(s_x), .y(s_y),
    .busy(s_busy), .done(s_done), .prod(s_prod), .quot(s_quot), .rem(s_rem)
  );

  // signed quotient from magnitude quotient
  function automatic word_t sfix(input word_t q, input logic neg);
    sfix = neg ? word_t'(-q) : q;
  endfunction

  logic launch;
  assign launch = req.valid && req.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (launch) begin
          unique case (req.data.action)
            ACT_MUL, ACT_DIV: state_next = ST_MUL1;
            ACT_ADD, ACT_SUB: begin
              if (req.data.a_den == '0 || req.data.b_den == '0) state_next = ST_DONE;
              else state_next = ST_MUL1;
            end
            ACT_RED: state_next = (req.data.a_den == '0) ? ST_DONE : ST_GCD;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_MUL1: if (s_done) state_next = ST_MUL2;
      ST_MUL2: begin
        if (s_done) state_next = (r.action == ACT_ADD || r.action == ACT_SUB) ? ST_GCD : ST_DONE;
      end
      ST_GCD: if (!s_busy && !s_start && gy == '0) state_next =
                 (r.action == ACT_RED) ? ST_RN : ST_LCD;
      ST_LCD:  if (s_done) state_next = ST_Q1;
      ST_Q1:   if (s_done) state_next = ST_Q2;
      ST_Q2:   if (s_done) state_next = ST_T1;
      ST_T1:   if (s_done) state_next = ST_T2;
      ST_T2:   if (s_done) state_next = ST_DONE;
      ST_RN:   if (s_done) state_next = ST_RD;
      ST_RD:   if (s_done) state_next = ST_DONE;
      ST_DONE: if (rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // serial unit launches: start one pass on entry to each step; ST_GCD starts one per remainder until gy is zero
  logic entered;
  always_comb begin
    s_start = 1'b0;
    s_div   = 1'b0;
    s_x     = '0;
    s_y     = '1;
    unique case (state)
      ST_MUL1: begin
        s_start = entered;
        s_x = r.a_num;
        s_y = (r.action == ACT_DIV) ? r.b_den : r.b_num;
      end
      ST_MUL2: begin
        s_start = entered;
        s_x = r.a_den;
        s_y = (r.action == ACT_DIV) ? r.b_num : r.b_den;
      end
      ST_GCD: begin
        s_start = !s_busy && !s_done && gy != '0 && !entered;
        s_div = 1'b1; s_x = gx; s_y = gy;
      end
      ST_LCD: begin s_start = entered; s_div = 1'b1; s_x = mag(p0); s_y = gx; end
      ST_Q1:  begin s_start = entered; s_div = 1'b1; s_x = mag(lcd); s_y = mag(r.a_den); end
      ST_Q2:  begin s_start = entered; s_div = 1'b1; s_x = mag(lcd); s_y = mag(r.b_den); end
      ST_T1:  begin s_start = entered; s_x = r.a_num; s_y = q1; end
      ST_T2:  begin s_start = entered; s_x = r.b_num; s_y = q2; end
      ST_RN:  begin s_start = entered; s_div = 1'b1; s_x = mag(r.a_num); s_y = gx; end
      ST_RD:  begin s_start = entered; s_div = 1'b1; s_x = mag(r.a_den); s_y = gx; end
      default: ;
    endcase
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = (state == ST_DONE);
  always_comb begin
    rsp.data.zero_den_error = bad || rd == '0;
    rsp.data.res_num = rsp.data.zero_den_error ? '0 : rn;
    rsp.data.res_den = rsp.data.zero_den_error ? '0 : rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      entered <= 1'b0;
    end else begin
      state   <= state_next;
      entered <= (state_next != state) || (state == ST_GCD && s_done);
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      r   <= req.data;
      rn  <= '0;
      rd  <= '0;
      gx  <= mag(req.data.a_num);
      gy  <= mag(req.data.a_den);
      unique case (req.data.action)
        ACT_MUL, ACT_DIV: bad <= 1'b0;
        ACT_ADD, ACT_SUB: bad <= (req.data.a_den == '0 || req.data.b_den == '0);
        ACT_RED: bad <= (req.data.a_den == '0);
        default: bad <= 1'b1;
      endcase
    end else if (s_done) begin
      unique case (state)
        ST_MUL1: rn <= s_prod;
        ST_MUL2: begin
          rd <= s_prod;
          p0 <= s_prod;
          // gcd operands for the common denominator
          gx <= mag(r.a_den);
          gy <= mag(r.b_den);
        end
        ST_GCD: begin gx <= gy; gy <= s_rem; end
        // a gcd of 2^(DataWidth-1) carries a set sign bit and flips the quotient
        ST_LCD: lcd <= sfix(s_quot, p0[DataWidth-1] ^ gx[DataWidth-1]);
        ST_Q1:  q1 <= sfix(s_quot, lcd[DataWidth-1] ^ r.a_den[DataWidth-1]);
        ST_Q2:  q2 <= sfix(s_quot, lcd[DataWidth-1] ^ r.b_den[DataWidth-1]);
        ST_T1:  t1 <= s_prod;
        ST_T2: begin
          rn <= (r.action == ACT_ADD) ? t1 + s_prod : t1 - s_prod;
          rd <= lcd;
        end
        ST_RN:  rn <= sfix(s_quot, r.a_num[DataWidth-1] ^ gx[DataWidth-1]);
        ST_RD:  rd <= sfix(s_quot, r.a_den[DataWidth-1] ^ gx[DataWidth-1]);
        default: ;
      endcase
    end
  end

endmodule

>>> sv/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
module rau_checker import rau_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result dropped or changed under stall");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request taken while result pending");

  a_err: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.zero_den_error |-> rsp_data.res_den == '0 && rsp_data.res_num == '0)
    else $error("error result with nonzero fields");

  a_nzden: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.zero_den_error |-> rsp_data.res_den != '0)
    else $error("valid result with zero denominator");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready stayed high after a request");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

>>> bench/tb_rational_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit_top
// Drives fraction requests through the unit under random sender gaps and
// receiver stalls, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit_top;
  import rau_pkg::*;

  localparam int WatchdogLimit = 40000;
  localparam int DrainCycles   = 100;

  logic clk;
  logic rst;
  int   errors;
  int   idle_cycles;
  bit   long_hold;
  rsp_t expected_results[$];

  rau_req_if req ();
  rau_rsp_if rsp ();

  rational_arithmetic_unit_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic word_t magnitude_of(input word_t v);
    return v[DataWidth-1] ? word_t'(-v) : v;
  endfunction

  function automatic word_t signed_quotient(input word_t n, input word_t d);
    word_t q;
    q = magnitude_of(n) / magnitude_of(d);
    if (n[DataWidth-1] != d[DataWidth-1]) q = word_t'(-q);
    return q;
  endfunction

  function automatic word_t gcd_of(input word_t a, input word_t b);
    word_t x, y, t;
    x = magnitude_of(a);
    y = magnitude_of(b);
    while (y != '0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic rsp_t fraction_result(input req_t r);
    rsp_t  o;
    word_t lcd, t1, t2, g;
    bit    bad;
    o   = '0;
    bad = 1'b0;
    case (r.action)
      ACT_MUL: begin
        o.res_num = r.a_num * r.b_num;
        o.res_den = r.a_den * r.b_den;
      end
      ACT_DIV: begin
        o.res_num = r.a_num * r.b_den;
        o.res_den = r.a_den * r.b_num;
      end
      ACT_ADD, ACT_SUB: begin
        if (r.a_den == '0 || r.b_den == '0) begin
          bad = 1'b1;
        end else begin
          lcd = signed_quotient(word_t'(r.a_den * r.b_den), gcd_of(r.a_den, r.b_den));
          t1  = r.a_num * signed_quotient(lcd, r.a_den);
          t2  = r.b_num * signed_quotient(lcd, r.b_den);
          o.res_num = (r.action == ACT_ADD) ? word_t'(t1 + t2) : word_t'(t1 - t2);
          o.res_den = lcd;
        end
      end
      ACT_RED: begin
        if (r.a_den == '0) begin
          bad = 1'b1;
        end else begin
          g = gcd_of(r.a_num, r.a_den);
          o.res_num = signed_quotient(r.a_num, g);
          o.res_den = signed_quotient(r.a_den, g);
        end
      end
      default: bad = 1'b1;
    endcase
    if (o.res_den == '0) bad = 1'b1;
    if (bad) begin
      o.res_num = '0;
      o.res_den = '0;
    end
    o.zero_den_error = bad;
    return o;
  endfunction

  // Send one request; hold valid until the unit takes it.
  task automatic send_request(input logic [ActWidth-1:0] act, input word_t an,
                              input word_t ad, input word_t bn, input word_t bd);
    req_t r;
    r.action = act;
    r.a_num  = an;
    r.a_den  = ad;
    r.b_num  = bn;
    r.b_den  = bd;
    req.valid <= 1'b1;
    req.data  <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_results.push_back(fraction_result(r));
  endtask

  task automatic pause_sender(input int cycles);
    req.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic word_t random_word();
    case ($urandom_range(0, 5))
      0:       return word_t'($signed($urandom_range(0, 20)) - 10);
      1:       return {1'b1, {(DataWidth-1){1'b0}}};
      2:       return word_t'($urandom_range(1, 1000)) * word_t'($urandom_range(1, 60));
      3:       return word_t'(-($urandom_range(1, 5000)));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t random_den();
    word_t d;
    d = random_word();
    if ($urandom_range(0, 40) == 0) d = '0;
    return d;
  endfunction

  task automatic test_directed();
    word_t mn, mx;
    mn = {1'b1, {(DataWidth-1){1'b0}}};
    mx = {1'b0, {(DataWidth-1){1'b1}}};
    send_request(ACT_MUL, 3, 4, 5, 7);
    send_request(ACT_MUL, mx, mn, mx, -1);
    send_request(ACT_MUL, 1, 0, 2, 3);
    send_request(ACT_DIV, 3, 4, 5, 7);
    send_request(ACT_DIV, 1, 2, 0, 5);
    send_request(ACT_DIV, mn, mx, -1, mn);
    send_request(ACT_ADD, 1, 6, 1, 4);
    send_request(ACT_ADD, mx, 1, 1, 1);
    send_request(ACT_ADD, 1, 0, 1, 3);
    send_request(ACT_ADD, mn, -1, 3, mn);
    send_request(ACT_SUB, 1, 6, 1, 4);
    send_request(ACT_SUB, -5, -12, 7, 18);
    send_request(ACT_SUB, 2, 3, 1, 0);
    send_request(ACT_SUB, 1, mn, 1, mn);
    send_request(ACT_RED, 12, 18, 0, 0);
    send_request(ACT_RED, 0, -7, 0, 0);
    send_request(ACT_RED, 5, 0, 0, 0);
    send_request(ACT_RED, mn, -1, 0, 0);
    send_request(ACT_RED, mn, mn, 0, 0);
    send_request(ACT_RED, -1, -1, -1, -1);
    send_request(3'd5, 1, 1, 1, 1);
    send_request(3'd6, 1, 1, 1, 1);
    send_request(3'd7, -1, -1, -1, -1);
  endtask

  task automatic test_random(input int count);
    int burst;
    logic [ActWidth-1:0] act;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 150));
      end
      burst--;
      act = ($urandom_range(0, 19) == 0) ? ActWidth'($urandom_range(5, 7))
                                         : ActWidth'($urandom_range(0, 4));
      send_request(act, random_word(), random_den(), random_word(), random_den());
    end
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    long_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
      test_random(8);
    join
  endtask

  task automatic test_drain_then_send();
    while (expected_results.size() != 0) @(posedge clk);
    test_random(10);
  endtask

  // Receiver stall pattern, independent of the sender.
  initial begin
    int phase;
    rsp.ready = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (long_hold) rsp.ready <= 1'b0;
      else if (phase % 400 < 150) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result num=%h den=%h err=%b", $time,
                 rsp.data.res_num, rsp.data.res_den, rsp.data.zero_den_error);
        errors++;
      end else begin
        rsp_t e;
        e = expected_results.pop_front();
        if (rsp.data.res_num !== e.res_num) begin
          $display("%0t: res_num expected %h actual %h", $time, e.res_num,
                   rsp.data.res_num);
          errors++;
        end
        if (rsp.data.res_den !== e.res_den) begin
          $display("%0t: res_den expected %h actual %h", $time, e.res_den,
                   rsp.data.res_den);
          errors++;
        end
        if (rsp.data.zero_den_error !== e.zero_den_error) begin
          $display("%0t: zero_den_error expected %b actual %b", $time,
                   e.zero_den_error, rsp.data.zero_den_error);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel, outside the long hold.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || long_hold) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("** rational_arithmetic_unit_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    errors       = 0;
    idle_cycles  = 0;
    long_hold    = 1'b0;
    rst          = 1'b1;
    req.valid    = 1'b0;
    req.data     = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_drain_then_send();
    test_random(360);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** rational_arithmetic_unit_top: PASSED **");
    end else begin
      $display("** rational_arithmetic_unit_top: FAILED **");
    end
    $finish;
  end

endmodule
